@@ hdl/lamm_pkg.sv @@
// Shared types, constants and helpers for the look-at model matrix core.
package lamm_pkg;

  localparam int SQ_STEPS  = 31;  // root bits of isqrt(sum << 30)
  localparam int DIV_STEPS = 15;  // quotient bits of the normalizing divide
  localparam logic [14:0] UNIT_Q14 = 15'd16384;
  localparam logic [1:0]  ROW_LAST = 2'd2;

  typedef logic [15:0] mag_t;

  typedef struct packed {
    logic [2:0][15:0] scale;
    logic [2:0][23:0] pos;
    logic [2:0][15:0] look;
    logic [2:0][15:0] depth;
  } side_t;

  function automatic mag_t abs16(input logic [15:0] v);
    return v[15] ? mag_t'(-v) : v;
  endfunction

endpackage

@@ hdl/lamm_norm.sv @@
// Pipelined 3-vector normalizer: sum of squares, bit-per-stage isqrt, bit-per-stage divide.
module lamm_norm
  import lamm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  mag_t [2:0]       in_mag,
  input  logic [2:0]       in_neg,
  input  side_t            in_side,
  output logic             out_v,
  output logic [2:0][15:0] out_vec,
  output side_t            out_side
);

  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
    side_t      side;
  } carry_t;

  // sum of squares
  logic        v0;
  logic [31:0] sum0;
  carry_t      c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_v;
    end
    if (en) begin
      sum0 <= 32'(in_mag[0]) * 32'(in_mag[0]) + 32'(in_mag[1]) * 32'(in_mag[1])
            + 32'(in_mag[2]) * 32'(in_mag[2]);
      c0.mag  <= in_mag;
      c0.neg  <= in_neg;
      c0.side <= in_side;
    end
  end

  // square root, one result bit per stage
  logic        sq_v    [SQ_STEPS];
  logic [32:0] sq_rem  [SQ_STEPS];
  logic [30:0] sq_root [SQ_STEPS];
  logic [31:0] sq_sum  [SQ_STEPS];
  carry_t      sq_c    [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic        pv;
    logic [32:0] prem;
    logic [30:0] proot;
    logic [31:0] psum;
    carry_t      pc;
    logic [61:0] rad;
    logic [34:0] rem_s;
    logic [34:0] trial;
    logic [32:0] rem_n;
    logic [30:0] root_n;

    if (k == 0) begin : g_first
      assign pv    = v0;
      assign prem  = '0;
      assign proot = '0;
      assign psum  = sum0;
      assign pc    = c0;
    end else begin : g_next
      assign pv    = sq_v[k-1];
      assign prem  = sq_rem[k-1];
      assign proot = sq_root[k-1];
      assign psum  = sq_sum[k-1];
      assign pc    = sq_c[k-1];
    end

    always_comb begin
      rad   = {psum, 30'b0};
      rem_s = {prem, rad[2*(SQ_STEPS-1-k) +: 2]};
      trial = {2'b00, proot, 2'b01};
      if (rem_s >= trial) begin
        rem_n  = 33'(rem_s - trial);
        root_n = {proot[29:0], 1'b1};
      end else begin
        rem_n  = rem_s[32:0];
        root_n = {proot[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= pv;
      end
      if (en) begin
        sq_rem[k]  <= rem_n;
        sq_root[k] <= root_n;
        sq_sum[k]  <= psum;
        sq_c[k]    <= pc;
      end
    end
  end

  // dividend setup: (mag << 29) + len/2
  logic             d0_v;
  logic [2:0][44:0] d0_num;
  logic [30:0]      d0_len;
  carry_t           d0_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
    end else if (en) begin
      d0_v <= sq_v[SQ_STEPS-1];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d0_num[i] <= {sq_c[SQ_STEPS-1].mag[i], 29'b0}
                   + 45'(sq_root[SQ_STEPS-1][30:1]);
      end
      d0_len <= sq_root[SQ_STEPS-1];
      d0_c   <= sq_c[SQ_STEPS-1];
    end
  end

  // restoring divide, three lanes, one quotient bit per stage
  logic             dv_v   [DIV_STEPS];
  logic [2:0][30:0] dv_rem [DIV_STEPS];
  logic [2:0][14:0] dv_q   [DIV_STEPS];
  logic [2:0][44:0] dv_num [DIV_STEPS];
  logic [30:0]      dv_len [DIV_STEPS];
  carry_t           dv_c   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    logic             pv;
    logic [2:0][30:0] prem;
    logic [2:0][14:0] pq;
    logic [2:0][44:0] pnum;
    logic [30:0]      plen;
    carry_t           pc;
    logic [2:0][31:0] rem2;
    logic [2:0][30:0] rem_n;
    logic [2:0][14:0] q_n;

    if (j == 0) begin : g_first
      assign pv   = d0_v;
      assign pq   = '0;
      assign pnum = d0_num;
      assign plen = d0_len;
      assign pc   = d0_c;
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign prem[i] = {1'b0, d0_num[i][44:15]};
      end
    end else begin : g_next
      assign pv   = dv_v[j-1];
      assign prem = dv_rem[j-1];
      assign pq   = dv_q[j-1];
      assign pnum = dv_num[j-1];
      assign plen = dv_len[j-1];
      assign pc   = dv_c[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {prem[i], pnum[i][DIV_STEPS-1-j]};
        if (rem2[i] >= {1'b0, plen}) begin
          rem_n[i] = 31'(rem2[i] - {1'b0, plen});
          q_n[i]   = {pq[i][13:0], 1'b1};
        end else begin
          rem_n[i] = rem2[i][30:0];
          q_n[i]   = {pq[i][13:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= pv;
      end
      if (en) begin
        dv_rem[j] <= rem_n;
        dv_q[j]   <= q_n;
        dv_num[j] <= pnum;
        dv_len[j] <= plen;
        dv_c[j]   <= pc;
      end
    end
  end

  // clamp, sign, zero-length vector
  logic [2:0][15:0] vec_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [14:0] qc;
      qc = (dv_q[DIV_STEPS-1][i] > UNIT_Q14) ? UNIT_Q14 : dv_q[DIV_STEPS-1][i];
      if (dv_len[DIV_STEPS-1] == '0) begin
        vec_n[i] = '0;
      end else if (dv_c[DIV_STEPS-1].neg[i]) begin
        vec_n[i] = 16'(-{1'b0, qc});
      end else begin
        vec_n[i] = {1'b0, qc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv_v[DIV_STEPS-1];
    end
    if (en) begin
      out_vec  <= vec_n;
      out_side <= dv_c[DIV_STEPS-1].side;
    end
  end

endmodule

@@ hdl/lamm_cross.sv @@
// Two-stage look x depth cross product, rounded to Q1.14 sign and magnitude.
module lamm_cross
  import lamm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  side_t            in_side,
  output logic             out_v,
  output mag_t [2:0]       out_mag,
  output logic [2:0]       out_neg,
  output side_t            out_side
);

  logic               p_v;
  logic signed [31:0] pa [6];
  side_t              p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= in_v;
    end
    if (en) begin
      pa[0] <= $signed(in_side.look[1]) * $signed(in_side.depth[2]);
      pa[1] <= $signed(in_side.look[2]) * $signed(in_side.depth[1]);
      pa[2] <= $signed(in_side.look[2]) * $signed(in_side.depth[0]);
      pa[3] <= $signed(in_side.look[0]) * $signed(in_side.depth[2]);
      pa[4] <= $signed(in_side.look[0]) * $signed(in_side.depth[1]);
      pa[5] <= $signed(in_side.look[1]) * $signed(in_side.depth[0]);
      p_side <= in_side;
    end
  end

  logic signed [32:0] diff [3];
  mag_t [2:0]         mag_n;
  logic [2:0]         neg_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [32:0] m;
      logic [33:0] r;
      diff[i]  = 33'(pa[2*i]) - 33'(pa[2*i+1]);
      m        = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
      r        = (34'(m) + 34'd8192) >> 14;
      mag_n[i] = r[15:0];
      neg_n[i] = diff[i][32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= p_v;
    end
    if (en) begin
      out_mag  <= mag_n;
      out_neg  <= neg_n;
      out_side <= p_side;
    end
  end

endmodule

@@ hdl/lamm_rows.sv @@
// Scaled row entries with saturation, and the three-row output serializer.
module lamm_rows
  import lamm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_v,
  input  logic [2:0][15:0]   in_up,
  input  side_t              in_side,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row,
  output logic signed [15:0] col0,
  output logic signed [15:0] col1,
  output logic signed [15:0] col2,
  output logic signed [23:0] translation,
  output logic               last_row
);

  function automatic logic [15:0] sat_entry(input logic signed [31:0] p);
    logic [31:0] m;
    logic [17:0] r;
    logic [15:0] res;
    m = p[31] ? 32'(-p) : 32'(p);
    r = 18'((m + 32'd8192) >> 14);
    if (p[31]) begin
      res = (r > 18'd32768) ? 16'h8000 : 16'(-r);
    end else begin
      res = (r > 18'd32767) ? 16'h7fff : r[15:0];
    end
    return res;
  endfunction

  logic [2:0][2:0][15:0] vecs;
  assign vecs[0] = in_side.look;
  assign vecs[1] = in_up;
  assign vecs[2] = in_side.depth;

  logic                  e_v;
  logic signed [31:0]    prod [3][3];
  logic [2:0][23:0]      e_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= in_v;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod[k][i] <= $signed(vecs[k][i]) * $signed(in_side.scale[k]);
        end
      end
      e_pos <= in_side.pos;
    end
  end

  logic [1:0]            cnt;
  logic [2:0][2:0][15:0] ent;
  logic [2:0][23:0]      tr;
  logic                  ser_free;
  logic                  load;

  assign ser_free = !out_valid || (out_ready && cnt == ROW_LAST);
  assign load     = e_v && ser_free;
  assign adv      = !e_v || ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      cnt       <= '0;
    end else if (out_valid && out_ready) begin
      if (cnt == ROW_LAST) begin
        out_valid <= 1'b0;
        cnt       <= '0;
      end else begin
        cnt <= 2'(cnt + 2'd1);
      end
    end
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          ent[k][i] <= sat_entry(prod[k][i]);
        end
      end
      tr <= e_pos;
    end
  end

  always_comb begin
    case (cnt)
      2'd0: begin
        col0 = ent[0][0]; col1 = ent[0][1]; col2 = ent[0][2]; translation = tr[0];
      end
      2'd1: begin
        col0 = ent[1][0]; col1 = ent[1][1]; col2 = ent[1][2]; translation = tr[1];
      end
      default: begin
        col0 = ent[2][0]; col1 = ent[2][1]; col2 = ent[2][2]; translation = tr[2];
      end
    endcase
  end

  assign row      = cnt;
  assign last_row = (cnt == ROW_LAST);

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && cnt != ROW_LAST |=> out_valid && cnt == 2'($past(cnt) + 2'd1))
    else $error("row sequence broken");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cnt))
    else $error("row changed while stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    e_v && !adv |=> e_v)
    else $error("stalled item lost");

endmodule

@@ hdl/look_at_model_matrix_core.sv @@
// Look-at model matrix core: three normalizer pipelines, cross product, row serializer.
// After the first row, the other two rows follow one per cycle while out_ready is high.
// The serializer drives each item's three rows on one port; the next item loads as its last row is taken.
// The pipeline takes a beat every cycle until the serializer backs up; one global stall holds it.
// Reset (rst, synchronous) clears all valid bits and the row counter; data registers keep values.
module look_at_model_matrix_core
  import lamm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] look_x,
  input  logic signed [15:0] look_y,
  input  logic signed [15:0] look_z,
  input  logic signed [15:0] scale_x,
  input  logic signed [15:0] scale_y,
  input  logic signed [15:0] scale_z,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row,
  output logic signed [15:0] col0,
  output logic signed [15:0] col1,
  output logic signed [15:0] col2,
  output logic signed [23:0] translation,
  output logic               last_row
);

  logic adv;
  assign in_ready = adv;

  // look normalize
  mag_t [2:0] a_mag;
  logic [2:0] a_neg;
  side_t      a_side;

  assign a_mag        = {abs16(look_z), abs16(look_y), abs16(look_x)};
  assign a_neg        = {look_z[15], look_y[15], look_x[15]};
  assign a_side.scale = {scale_z, scale_y, scale_x};
  assign a_side.pos   = {pos_z, pos_y, pos_x};
  assign a_side.look  = '0;
  assign a_side.depth = '0;

  logic             la_v;
  logic [2:0][15:0] la_vec;
  side_t            la_side;

  lamm_norm u_norm_look (
    .clk, .rst, .en(adv),
    .in_v(in_valid), .in_mag(a_mag), .in_neg(a_neg), .in_side(a_side),
    .out_v(la_v), .out_vec(la_vec), .out_side(la_side)
  );

  // depth = (0,1,0) x look = (look.z, 0, -look.x)
  mag_t [2:0] b_mag;
  logic [2:0] b_neg;
  side_t      b_side;

  assign b_mag = {abs16(la_vec[0]), 16'd0, abs16(la_vec[2])};
  assign b_neg = {~la_vec[0][15], 1'b0, la_vec[2][15]};

  always_comb begin
    b_side      = la_side;
    b_side.look = la_vec;
  end

  logic             lb_v;
  logic [2:0][15:0] lb_vec;
  side_t            lb_side;

  lamm_norm u_norm_depth (
    .clk, .rst, .en(adv),
    .in_v(la_v), .in_mag(b_mag), .in_neg(b_neg), .in_side(b_side),
    .out_v(lb_v), .out_vec(lb_vec), .out_side(lb_side)
  );

  side_t c_side;

  always_comb begin
    c_side       = lb_side;
    c_side.depth = lb_vec;
  end

  logic       cx_v;
  mag_t [2:0] cx_mag;
  logic [2:0] cx_neg;
  side_t      cx_side;

  lamm_cross u_cross (
    .clk, .rst, .en(adv),
    .in_v(lb_v), .in_side(c_side),
    .out_v(cx_v), .out_mag(cx_mag), .out_neg(cx_neg), .out_side(cx_side)
  );

  logic             up_v;
  logic [2:0][15:0] up_vec;
  side_t            up_side;

  lamm_norm u_norm_up (
    .clk, .rst, .en(adv),
    .in_v(cx_v), .in_mag(cx_mag), .in_neg(cx_neg), .in_side(cx_side),
    .out_v(up_v), .out_vec(up_vec), .out_side(up_side)
  );

  lamm_rows u_rows (
    .clk, .rst,
    .in_v(up_v), .in_up(up_vec), .in_side(up_side),
    .adv,
    .out_valid, .out_ready,
    .row, .col0, .col1, .col2, .translation, .last_row
  );

endmodule

@@ tb/sv/tb_look_at_model_matrix_core.sv @@
// Self-checking testbench for the look-at model matrix core: random beats, row predictor.
module tb_look_at_model_matrix_core
  import lamm_pkg::*;
();

  typedef struct {
    logic signed [15:0] look [3];
    logic signed [15:0] scale [3];
    logic signed [23:0] pos [3];
  } pose_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [15:0] col [3];
    logic signed [23:0] translation;
    logic               last_row;
  } mrow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] look_x = '0, look_y = '0, look_z = '0;
  logic signed [15:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row;
  logic signed [15:0] col0, col1, col2;
  logic signed [23:0] translation;
  logic last_row;

  pose_t pending_poses[$];
  mrow_t expected_rows[$];
  int    errors = 0;
  int    rows_seen = 0;
  int    beats_sent = 0;
  int    tx_wait = 0;
  int    rx_wait = 0;
  int    drain_at = -1;
  bit    stim_done = 0;

  look_at_model_matrix_core u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned sqrt_floor(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_q14(input longint p);
    longint unsigned m;
    m = ((p < 0 ? -p : p) + 64'd8192) >> 14;
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned sum, len, q, m;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      sum += m * m;
    end
    len = sqrt_floor(sum << 30);
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = ((m << 29) + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic logic signed [15:0] sat_entry(input longint u, input longint s);
    longint r;
    r = round_q14(u * s);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void predict_rows(input pose_t p);
    longint raw[3], lk[3], draw[3], dp[3], uraw[3], up[3];
    mrow_t r;
    for (int i = 0; i < 3; i++) raw[i] = longint'(p.look[i]);
    unit_vec(raw, lk);
    draw[0] = lk[2];
    draw[1] = 0;
    draw[2] = -lk[0];
    unit_vec(draw, dp);
    uraw[0] = round_q14(lk[1] * dp[2] - lk[2] * dp[1]);
    uraw[1] = round_q14(lk[2] * dp[0] - lk[0] * dp[2]);
    uraw[2] = round_q14(lk[0] * dp[1] - lk[1] * dp[0]);
    unit_vec(uraw, up);
    for (int k = 0; k < 3; k++) begin
      r.row = k[1:0];
      for (int i = 0; i < 3; i++)
        r.col[i] = sat_entry(k == 0 ? lk[i] : (k == 1 ? up[i] : dp[i]),
                             longint'(p.scale[k]));
      r.translation = p.pos[k];
      r.last_row = (r.row == ROW_LAST);
      expected_rows.push_back(r);
    end
  endfunction

  function automatic pose_t make_pose(input int lx, ly, lz, sx, sy, sz, input int px, py, pz);
    pose_t p;
    p.look[0] = 16'(lx); p.look[1] = 16'(ly); p.look[2] = 16'(lz);
    p.scale[0] = 16'(sx); p.scale[1] = 16'(sy); p.scale[2] = 16'(sz);
    p.pos[0] = 24'(px); p.pos[1] = 24'(py); p.pos[2] = 24'(pz);
    return p;
  endfunction

  function automatic int rnd_look();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;  // any 16-bit pattern
      1: return $urandom_range(0, 64) - 32;        // tiny vectors
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  function automatic int rnd_scale();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic pose_t rnd_pose();
    pose_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p = make_pose(rnd_look(), rnd_look(), rnd_look(), rnd_scale(), rnd_scale(), rnd_scale(),
                  $urandom, $urandom, $urandom);
    if (mode == 0) begin
      p.look[0] = '0;  // along world up
      p.look[2] = '0;
    end else if (mode == 1) begin
      p.look[$urandom_range(0, 2)] = '0;
    end
    return p;
  endfunction

  // directed corners, then random
  initial begin
    pending_poses.push_back(make_pose(0, 0, 0, 256, 256, 256, 1, 2, 3));
    pending_poses.push_back(make_pose(16384, 0, 0, 256, 256, 256, 8388607, -8388608, 0));
    pending_poses.push_back(make_pose(0, 16384, 0, 256, 256, 256, -1, 0, 1));
    pending_poses.push_back(make_pose(0, -16384, 0, 32767, -32768, 100, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 0, 16384, 32767, 32767, 32767, 5, 6, 7));
    pending_poses.push_back(make_pose(0, 0, -16384, -32768, -32768, -32768, 0, 0, 0));
    pending_poses.push_back(make_pose(-16384, -16384, -16384, 256, -256, 512, -8388608, 8388607, 0));
    pending_poses.push_back(make_pose(16384, 16384, 16384, 32767, 32767, 32767, 0, 0, 0));
    pending_poses.push_back(make_pose(32767, -32768, 32767, 32767, -32768, 32767, 0, 0, 0));
    pending_poses.push_back(make_pose(-32768, -32768, -32768, -1, 1, 0, -1, -1, -1));
    pending_poses.push_back(make_pose(1, 0, 0, 256, 256, 256, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_poses.push_back(make_pose(-1, 1, -1, 4096, 4096, 4096, 0, 0, 0));
    pending_poses.push_back(make_pose(3, -4, 0, 32767, 32767, -32768, 123, 456, 789));
    for (int i = 0; i < 320; i++) pending_poses.push_back(rnd_pose());
  end

  // driver: in_valid held until the beat is taken
  always @(posedge clk) begin
    if (!rst && !stim_done) begin
      if (in_valid && in_ready) begin
        beats_sent++;
        tx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (!in_valid || in_ready) begin
        if (beats_sent == 150 && expected_rows.size() != 0) begin
          in_valid <= 1'b0;  // let the pipeline drain once
        end else if (pending_poses.size() == 0) begin
          in_valid <= 1'b0;
          stim_done = 1;
        end else if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else begin
          pose_t p;
          p = pending_poses.pop_front();
          predict_rows(p);
          look_x <= p.look[0]; look_y <= p.look[1]; look_z <= p.look[2];
          scale_x <= p.scale[0]; scale_y <= p.scale[1]; scale_z <= p.scale[2];
          pos_x <= p.pos[0]; pos_y <= p.pos[1]; pos_z <= p.pos[2];
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor and random stall on the result side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row %0d", $time, row);
          errors++;
        end else begin
          mrow_t e;
          e = expected_rows.pop_front();
          if (row !== e.row || col0 !== e.col[0] || col1 !== e.col[1] || col2 !== e.col[2]
              || translation !== e.translation || last_row !== e.last_row) begin
            $display("%0t: mismatch exp row=%0d %0d %0d %0d t=%0d last=%0b", $time, e.row,
                     e.col[0], e.col[1], e.col[2], e.translation, e.last_row);
            $display("%0t:          act row=%0d %0d %0d %0d t=%0d last=%0b", $time, row,
                     col0, col1, col2, translation, last_row);
            errors++;
          end
        end
        rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_rows.size() == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d pose beats, checked %0d matrix rows (zero, axis, saturating cases).",
             beats_sent, rows_seen);
    if (errors == 0 && expected_rows.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lamm_pkg.sv
hdl/lamm_norm.sv
hdl/lamm_cross.sv
hdl/lamm_rows.sv
hdl/look_at_model_matrix_core.sv
tb/sv/tb_look_at_model_matrix_core.sv
